FILE: design/sha256_pkg.sv
// Shared types, constants and functions of the SHA-256 hash engine.
// Holds the queue command type, the initial hash values, the round constants
// and the sigma functions. Depends on nothing.
package sha256_pkg;

   localparam int unsigned QueueDepth   = 4;
   localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

   localparam logic [31:0] PadMarker = 32'h8000_0000;
   localparam logic [3:0]  LengthSlot = 4'd14;

   typedef struct packed {
      logic        finish;
      logic [31:0] word;
   } cmd_type;

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] val;
      case (idx)
         3'd0: val = 32'h6a09e667;
         3'd1: val = 32'hbb67ae85;
         3'd2: val = 32'h3c6ef372;
         3'd3: val = 32'ha54ff53a;
         3'd4: val = 32'h510e527f;
         3'd5: val = 32'h9b05688c;
         3'd6: val = 32'h1f83d9ab;
         3'd7: val = 32'h5be0cd19;
         default: val = 32'h6a09e667;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] val;
      case (r)
         6'd0:  val = 32'h428a2f98;
         6'd1:  val = 32'h71374491;
         6'd2:  val = 32'hb5c0fbcf;
         6'd3:  val = 32'he9b5dba5;
         6'd4:  val = 32'h3956c25b;
         6'd5:  val = 32'h59f111f1;
         6'd6:  val = 32'h923f82a4;
         6'd7:  val = 32'hab1c5ed5;
         6'd8:  val = 32'hd807aa98;
         6'd9:  val = 32'h12835b01;
         6'd10: val = 32'h243185be;
         6'd11: val = 32'h550c7dc3;
         6'd12: val = 32'h72be5d74;
         6'd13: val = 32'h80deb1fe;
         6'd14: val = 32'h9bdc06a7;
         6'd15: val = 32'hc19bf174;
         6'd16: val = 32'he49b69c1;
         6'd17: val = 32'hefbe4786;
         6'd18: val = 32'h0fc19dc6;
         6'd19: val = 32'h240ca1cc;
         6'd20: val = 32'h2de92c6f;
         6'd21: val = 32'h4a7484aa;
         6'd22: val = 32'h5cb0a9dc;
         6'd23: val = 32'h76f988da;
         6'd24: val = 32'h983e5152;
         6'd25: val = 32'ha831c66d;
         6'd26: val = 32'hb00327c8;
         6'd27: val = 32'hbf597fc7;
         6'd28: val = 32'hc6e00bf3;
         6'd29: val = 32'hd5a79147;
         6'd30: val = 32'h06ca6351;
         6'd31: val = 32'h14292967;
         6'd32: val = 32'h27b70a85;
         6'd33: val = 32'h2e1b2138;
         6'd34: val = 32'h4d2c6dfc;
         6'd35: val = 32'h53380d13;
         6'd36: val = 32'h650a7354;
         6'd37: val = 32'h766a0abb;
         6'd38: val = 32'h81c2c92e;
         6'd39: val = 32'h92722c85;
         6'd40: val = 32'ha2bfe8a1;
         6'd41: val = 32'ha81a664b;
         6'd42: val = 32'hc24b8b70;
         6'd43: val = 32'hc76c51a3;
         6'd44: val = 32'hd192e819;
         6'd45: val = 32'hd6990624;
         6'd46: val = 32'hf40e3585;
         6'd47: val = 32'h106aa070;
         6'd48: val = 32'h19a4c116;
         6'd49: val = 32'h1e376c08;
         6'd50: val = 32'h2748774c;
         6'd51: val = 32'h34b0bcb5;
         6'd52: val = 32'h391c0cb3;
         6'd53: val = 32'h4ed8aa4a;
         6'd54: val = 32'h5b9cca4f;
         6'd55: val = 32'h682e6ff3;
         6'd56: val = 32'h748f82ee;
         6'd57: val = 32'h78a5636f;
         6'd58: val = 32'h84c87814;
         6'd59: val = 32'h8cc70208;
         6'd60: val = 32'h90befffa;
         6'd61: val = 32'ha4506ceb;
         6'd62: val = 32'hbef9a3f7;
         6'd63: val = 32'hc67178f2;
         default: val = 32'h428a2f98;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

FILE: design/sha256_front.sv
// Front end of the SHA-256 hash engine: accepts message requests and pads.
// Emits at most one schedule word or finish command per cycle into the queue,
// and none while the queue is full. Depends on sha256_pkg.
module sha256_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_message_word,
   input  logic [2:0]           req_bytes_valid,
   input  logic                 req_last_word,
   input  logic                 queue_full,
   output logic                 cmd_valid,
   output sha256_pkg::cmd_type  cmd
);

   localparam logic [2:0] F_TAKE   = 3'd0;
   localparam logic [2:0] F_MARK   = 3'd1;
   localparam logic [2:0] F_ZERO   = 3'd2;
   localparam logic [2:0] F_LEN_HI = 3'd3;
   localparam logic [2:0] F_LEN_LO = 3'd4;
   localparam logic [2:0] F_DONE   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] keep;
   logic [31:0] marker;

   always_comb begin
      case (req_bytes_valid[1:0])
         2'd1: begin
            keep   = 32'hff00_0000;
            marker = 32'h0080_0000;
         end
         2'd2: begin
            keep   = 32'hffff_0000;
            marker = 32'h0000_8000;
         end
         2'd3: begin
            keep   = 32'hffff_ff00;
            marker = 32'h0000_0080;
         end
         default: begin
            keep   = 32'h0000_0000;
            marker = sha256_pkg::PadMarker;
         end
      endcase
   end

   assign req_stall = (state_ff != F_TAKE) || queue_full;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      cmd_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         F_TAKE: begin
            if (req_valid && !queue_full) begin
               cmd_valid = 1'b1;
               cnt_in    = cnt_ff + 4'd1;
               if (!req_last_word) begin
                  cmd.word = req_message_word;
                  len_in   = len_ff + 64'd32;
               end else if (req_bytes_valid inside {[3'd4:3'd7]}) begin
                  cmd.word = req_message_word;
                  len_in   = len_ff + 64'd32;
                  state_in = F_MARK;
               end else begin
                  cmd.word = (req_message_word & keep) | marker;
                  len_in   = len_ff + {59'd0, req_bytes_valid[1:0], 3'd0};
                  state_in = F_ZERO;
               end
            end
         end
         F_MARK: begin
            if (!queue_full) begin
               cmd_valid = 1'b1;
               cmd.word  = sha256_pkg::PadMarker;
               cnt_in    = cnt_ff + 4'd1;
               state_in  = F_ZERO;
            end
         end
         F_ZERO: begin
            if (cnt_ff == sha256_pkg::LengthSlot) begin
               state_in = F_LEN_HI;
            end else if (!queue_full) begin
               cmd_valid = 1'b1;
               cnt_in    = cnt_ff + 4'd1;
            end
         end
         F_LEN_HI: begin
            if (!queue_full) begin
               cmd_valid = 1'b1;
               cmd.word  = len_ff[63:32];
               cnt_in    = cnt_ff + 4'd1;
               state_in  = F_LEN_LO;
            end
         end
         F_LEN_LO: begin
            if (!queue_full) begin
               cmd_valid = 1'b1;
               cmd.word  = len_ff[31:0];
               cnt_in    = cnt_ff + 4'd1;
               state_in  = F_DONE;
            end
         end
         F_DONE: begin
            if (!queue_full) begin
               cmd_valid  = 1'b1;
               cmd.finish = 1'b1;
               cnt_in     = 4'd0;
               len_in     = 64'd0;
               state_in   = F_TAKE;
            end
         end
         default: begin
            state_in = F_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_TAKE;
         cnt_ff   <= 4'd0;
         len_ff   <= 64'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
      end
   end

endmodule

FILE: design/sha256_queue.sv
// Command queue between the front end and the compression core.
// Small register queue of sha256_pkg::cmd_type entries; depends on sha256_pkg.
module sha256_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sha256_pkg::cmd_type  push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output sha256_pkg::cmd_type  head
);

   localparam int unsigned PtrBits = sha256_pkg::QueuePtrBits;

   sha256_pkg::cmd_type mem_ff [sha256_pkg::QueueDepth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == (PtrBits + 1)'(sha256_pkg::QueueDepth));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/sha256_core.sv
// Back end of the SHA-256 hash engine: schedule window, 64-round compression
// and digest output register. Depends on sha256_pkg.
module sha256_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  sha256_pkg::cmd_type  queue_head,
   output logic                 queue_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_digest_word,
   output logic [2:0]           rsp_digest_index,
   output logic                 rsp_digest_last
);

   localparam logic [1:0] B_IDLE   = 2'd0;
   localparam logic [1:0] B_ROUND  = 2'd1;
   localparam logic [1:0] B_UPDATE = 2'd2;
   localparam logic [1:0] B_OUT    = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic [31:0] chain_ff  [8];
   logic [31:0] chain_in  [8];
   logic [31:0] vars_ff   [8];
   logic [31:0] vars_in   [8];
   logic [31:0] window_ff [16];
   logic [31:0] window_in [16];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] w_next;
   logic [31:0] shift_word;
   logic        shift_en;
   logic        rsp_take;

   assign t1 = vars_ff[7] + sha256_pkg::big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + sha256_pkg::round_k(round_ff) + window_ff[0];
   assign t2 = sha256_pkg::big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]));
   assign w_next = sha256_pkg::small_sigma1(window_ff[14]) + window_ff[9]
                 + sha256_pkg::small_sigma0(window_ff[1]) + window_ff[0];

   assign rsp_take  = !rsp_valid_ff || !rsp_stall;
   assign queue_pop = (state_ff == B_IDLE) && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      round_in     = round_ff;
      out_idx_in   = out_idx_ff;
      chain_in     = chain_ff;
      vars_in      = vars_ff;
      shift_en     = 1'b0;
      shift_word   = w_next;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               if (queue_head.finish) begin
                  out_idx_in = 3'd0;
                  state_in   = B_OUT;
               end else begin
                  shift_en   = 1'b1;
                  shift_word = queue_head.word;
                  cnt_in     = cnt_ff + 4'd1;
                  if (cnt_ff == 4'd15) begin
                     vars_in  = chain_ff;
                     round_in = 6'd0;
                     state_in = B_ROUND;
                  end
               end
            end
         end
         B_ROUND: begin
            shift_en   = 1'b1;
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            state_in = B_IDLE;
         end
         B_OUT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[out_idx_ff];
               rsp_index_in = out_idx_ff;
               rsp_last_in  = (out_idx_ff == 3'd7);
               out_idx_in   = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_in[i] = sha256_pkg::init_hash(3'(i));
                  end
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      window_in = window_ff;
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[15] = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      window_ff    <= window_in;
      vars_ff      <= vars_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= 4'd0;
         round_ff     <= 6'd0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha256_pkg::init_hash(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word  = rsp_word_ff;
   assign rsp_digest_index = rsp_index_ff;
   assign rsp_digest_last  = rsp_last_ff;

endmodule

FILE: design/sha256_hash_engine.sv
// SHA-256 hash engine top level: front end, command queue and compression core.
// A message word moves through the queue into the schedule window. Once 16 words
// of a block are in, the core runs 64 rounds, one round per cycle, then a chaining
// update, and pops no new words from the queue until the block is done. The last
// word adds padding pushes and one or two compressions; eight digest words follow,
// one per cycle when not stalled. Synchronous active-high reset restores the IV.
module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_bytes_valid,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last
);

   logic                cmd_valid;
   sha256_pkg::cmd_type cmd;
   logic                queue_full;
   logic                queue_empty;
   logic                queue_pop;
   sha256_pkg::cmd_type queue_head;

   sha256_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_word (req_message_word),
      .req_bytes_valid  (req_bytes_valid),
      .req_last_word    (req_last_word),
      .queue_full       (queue_full),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd)
   );

   sha256_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_cmd (cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head     (queue_head)
   );

   sha256_core u_core (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_head       (queue_head),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

endmodule
